// File: src/sge_pkg.sv
// Shared types and constants for the second greater element engine.
// Used by the channel interfaces and the top level.
package sge_pkg;

  localparam int MAX_LEN_DEF    = 64;
  localparam int VALUE_BITS_DEF = 32;
  localparam int IN_W           = 32;
  localparam int SG_W           = 32;
  localparam int IDX_W          = 6;
  localparam int CNT_W          = 7;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_R2_RD,
    ST_R2_CHK,
    ST_G_RD,
    ST_G_CHK,
    ST_E_RD,
    ST_E_OUT,
    ST_S1_RD,
    ST_S1_CHK,
    ST_C_RD,
    ST_C_WR,
    ST_PUSH,
    ST_F_RD,
    ST_F_OUT
  } state_t;

endpackage

// File: src/sge_if.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on sge_pkg for field widths.
interface sge_in_if;
  logic                     valid;
  logic                     ready;
  logic [sge_pkg::IN_W-1:0] value;
  logic                     last;
  modport source (output valid, output value, output last, input ready);
  modport sink (input valid, input value, input last, output ready);
endinterface

interface sge_out_if;
  logic                      valid;
  logic                      ready;
  logic [sge_pkg::IDX_W-1:0] index;
  logic                      found;
  logic [sge_pkg::SG_W-1:0]  second_greater;
  logic                      run_end;
  modport source (output valid, output index, output found, output second_greater,
                  output run_end, input ready);
  modport sink (input valid, input index, input found, input second_greater,
                input run_end, output ready);
endinterface

// File: src/sge_ram.sv
// Single-port-write, single-port-read stack memory with registered read data.
// No package dependencies.
module sge_ram #(
  parameter int WIDTH = 38,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/second_greater_element.sv
// Streaming second-greater-element engine. Values are numbered from 0 within a run; each
// element is answered with the second strictly greater value that follows it. Entries live
// in two stacks held in RAM: the decreasing stack and the pending stack, each entry
// {value, index}. Since every RAM read is registered, the time an input transaction takes
// grows with each decreasing-stack entry compared, each entry moved to the pending stack,
// each pending entry resolved and each resolved group of equal values; a nonempty pending
// stack adds a check of its top. A run end flushes every element, and output stalls add
// to all of these. One item is processed at a time, and the next is accepted once all its
// results are in the output register.
module second_greater_element #(
  parameter int MAX_LEN    = sge_pkg::MAX_LEN_DEF,
  parameter int VALUE_BITS = sge_pkg::VALUE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  sge_in_if.sink           in_ch,
  sge_out_if.source        out_ch
);

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int EW = VALUE_BITS + sge_pkg::IDX_W;
  localparam int CW = sge_pkg::CNT_W;
  localparam int IW = sge_pkg::IDX_W;
  localparam int IN_W_PAD = sge_pkg::IN_W;

  sge_pkg::state_t state_r, state_nxt;

  logic [VALUE_BITS-1:0] v_r, v_nxt, gv_r, gv_nxt;
  logic                  last_r, last_nxt;
  logic [CW-1:0]         cnt_r, cnt_nxt, d1_r, d1_nxt, d2_r, d2_nxt;
  logic [CW-1:0]         pa_r, pa_nxt, pb_r, pb_nxt, grp_r, grp_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [IW-1:0]         out_index_r, out_index_nxt;
  logic                  out_found_r, out_found_nxt;
  logic [sge_pkg::SG_W-1:0] out_sg_r, out_sg_nxt;
  logic                  out_end_r, out_end_nxt;

  logic          we1, re1, we2, re2;
  logic [AW-1:0] waddr1, raddr1, waddr2, raddr2;
  logic [EW-1:0] wdata1, wdata2, rd1, rd2;

  logic [VALUE_BITS-1:0] rd1_val, rd2_val;
  logic [IW-1:0]         rd1_idx, rd2_idx;
  logic                  out_free, emit, in_acc, take_b, fin, run_done;
  logic [VALUE_BITS+IN_W_PAD-1:0] in_ext;
  logic [VALUE_BITS+sge_pkg::SG_W-1:0] sg_ext;
  logic [CW-1:0]         cnt_inc;

  assign rd1_val = rd1[IW +: VALUE_BITS];
  assign rd1_idx = rd1[IW-1:0];
  assign rd2_val = rd2[IW +: VALUE_BITS];
  assign rd2_idx = rd2[IW-1:0];

  assign in_ext   = {{VALUE_BITS{1'b0}}, in_ch.value};
  assign sg_ext   = {{sge_pkg::SG_W{1'b0}}, v_r};
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cnt_inc  = cnt_r + CW'(1);
  assign take_b   = (pa_r == d1_r) || ((pb_r != d2_r) && (rd2_idx < rd1_idx));
  assign fin      = (pa_r + pb_r + CW'(1)) == (d1_r + d2_r);
  assign run_done = last_r || (cnt_inc >= CW'(MAX_LEN));

  assign in_ch.ready           = (state_r == sge_pkg::ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.index          = out_index_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.second_greater = out_sg_r;
  assign out_ch.run_end        = out_end_r;

  sge_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_stk1 (
    .clk(clk), .we(we1), .waddr(waddr1), .wdata(wdata1),
    .re(re1), .raddr(raddr1), .rdata(rd1)
  );

  sge_ram #(.WIDTH(EW), .DEPTH(MAX_LEN)) u_stk2 (
    .clk(clk), .we(we2), .waddr(waddr2), .wdata(wdata2),
    .re(re2), .raddr(raddr2), .rdata(rd2)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sge_pkg::ST_IDLE:   if (in_acc) state_nxt = sge_pkg::ST_R2_RD;
      sge_pkg::ST_R2_RD:  state_nxt = (d2_r == '0) ? sge_pkg::ST_S1_RD : sge_pkg::ST_R2_CHK;
      sge_pkg::ST_R2_CHK: state_nxt = (rd2_val < v_r) ? sge_pkg::ST_G_RD : sge_pkg::ST_S1_RD;
      sge_pkg::ST_G_RD:   state_nxt = (grp_r == '0) ? sge_pkg::ST_E_RD : sge_pkg::ST_G_CHK;
      sge_pkg::ST_G_CHK:  state_nxt = (rd2_val == gv_r) ? sge_pkg::ST_G_RD : sge_pkg::ST_E_RD;
      sge_pkg::ST_E_RD:   state_nxt = sge_pkg::ST_E_OUT;
      sge_pkg::ST_E_OUT: begin
        if (out_free) begin
          state_nxt = (pb_r == d2_r - CW'(1)) ? sge_pkg::ST_R2_RD : sge_pkg::ST_E_RD;
        end
      end
      sge_pkg::ST_S1_RD:  state_nxt = (pa_r == '0) ? sge_pkg::ST_C_RD : sge_pkg::ST_S1_CHK;
      sge_pkg::ST_S1_CHK: state_nxt = (rd1_val < v_r) ? sge_pkg::ST_S1_RD : sge_pkg::ST_C_RD;
      sge_pkg::ST_C_RD:   state_nxt = (pb_r == d1_r) ? sge_pkg::ST_PUSH : sge_pkg::ST_C_WR;
      sge_pkg::ST_C_WR:   state_nxt = sge_pkg::ST_C_RD;
      sge_pkg::ST_PUSH:   state_nxt = run_done ? sge_pkg::ST_F_RD : sge_pkg::ST_IDLE;
      sge_pkg::ST_F_RD:   state_nxt = sge_pkg::ST_F_OUT;
      sge_pkg::ST_F_OUT: begin
        if (out_free) begin
          state_nxt = fin ? sge_pkg::ST_IDLE : sge_pkg::ST_F_RD;
        end
      end
      default:            state_nxt = sge_pkg::ST_IDLE;
    endcase
  end

  // Datapath, RAM controls and result generation.
  always_comb begin
    v_nxt    = v_r;
    last_nxt = last_r;
    gv_nxt   = gv_r;
    cnt_nxt  = cnt_r;
    d1_nxt   = d1_r;
    d2_nxt   = d2_r;
    pa_nxt   = pa_r;
    pb_nxt   = pb_r;
    grp_nxt  = grp_r;
    we1 = 1'b0; re1 = 1'b0; we2 = 1'b0; re2 = 1'b0;
    waddr1 = d1_r[AW-1:0];
    waddr2 = d2_r[AW-1:0];
    raddr1 = pa_r[AW-1:0];
    raddr2 = pb_r[AW-1:0];
    wdata1 = {v_r, cnt_r[IW-1:0]};
    wdata2 = rd1;
    emit          = 1'b0;
    out_index_nxt = out_index_r;
    out_found_nxt = out_found_r;
    out_sg_nxt    = out_sg_r;
    out_end_nxt   = out_end_r;
    case (state_r)
      sge_pkg::ST_IDLE: begin
        if (in_acc) begin
          v_nxt    = in_ext[VALUE_BITS-1:0];
          last_nxt = in_ch.last;
          pa_nxt   = d1_r;
        end
      end
      sge_pkg::ST_R2_RD: begin
        re2    = (d2_r != '0);
        raddr2 = AW'(d2_r - CW'(1));
      end
      sge_pkg::ST_R2_CHK: begin
        gv_nxt  = rd2_val;
        grp_nxt = d2_r - CW'(1);
      end
      sge_pkg::ST_G_RD: begin
        // Walk down to the oldest entry of the equal-value group on top.
        if (grp_r == '0) begin
          pb_nxt = grp_r;
        end else begin
          re2    = 1'b1;
          raddr2 = AW'(grp_r - CW'(1));
        end
      end
      sge_pkg::ST_G_CHK: begin
        if (rd2_val == gv_r) begin
          grp_nxt = grp_r - CW'(1);
        end else begin
          pb_nxt = grp_r;
        end
      end
      sge_pkg::ST_E_RD: begin
        re2 = 1'b1;
      end
      sge_pkg::ST_E_OUT: begin
        if (out_free) begin
          emit          = 1'b1;
          out_index_nxt = rd2_idx;
          out_found_nxt = 1'b1;
          out_sg_nxt    = sg_ext[sge_pkg::SG_W-1:0];
          out_end_nxt   = 1'b0;
          if (pb_r == d2_r - CW'(1)) begin
            d2_nxt = grp_r;
          end else begin
            pb_nxt = pb_r + CW'(1);
          end
        end
      end
      sge_pkg::ST_S1_RD: begin
        if (pa_r == '0) begin
          pb_nxt = pa_r;
        end else begin
          re1    = 1'b1;
          raddr1 = AW'(pa_r - CW'(1));
        end
      end
      sge_pkg::ST_S1_CHK: begin
        if (rd1_val < v_r) begin
          pa_nxt = pa_r - CW'(1);
        end else begin
          pb_nxt = pa_r;
        end
      end
      sge_pkg::ST_C_RD: begin
        // Popped entries move to the pending stack in their original order.
        if (pb_r == d1_r) begin
          d1_nxt = pa_r;
        end else begin
          re1    = 1'b1;
          raddr1 = pb_r[AW-1:0];
        end
      end
      sge_pkg::ST_C_WR: begin
        we2    = 1'b1;
        d2_nxt = d2_r + CW'(1);
        pb_nxt = pb_r + CW'(1);
      end
      sge_pkg::ST_PUSH: begin
        we1     = 1'b1;
        d1_nxt  = d1_r + CW'(1);
        cnt_nxt = cnt_inc;
        pa_nxt  = '0;
        pb_nxt  = '0;
      end
      sge_pkg::ST_F_RD: begin
        re1 = 1'b1;
        re2 = 1'b1;
      end
      sge_pkg::ST_F_OUT: begin
        // Both stacks hold indices in ascending order; merge them.
        if (out_free) begin
          emit          = 1'b1;
          out_index_nxt = take_b ? rd2_idx : rd1_idx;
          out_found_nxt = 1'b0;
          out_sg_nxt    = '0;
          out_end_nxt   = fin;
          if (take_b) begin
            pb_nxt = pb_r + CW'(1);
          end else begin
            pa_nxt = pa_r + CW'(1);
          end
          if (fin) begin
            d1_nxt  = '0;
            d2_nxt  = '0;
            cnt_nxt = '0;
          end
        end
      end
      default: begin
      end
    endcase
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sge_pkg::ST_IDLE;
      cnt_r       <= '0;
      d1_r        <= '0;
      d2_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      d1_r        <= d1_nxt;
      d2_r        <= d2_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    v_r         <= v_nxt;
    last_r      <= last_nxt;
    gv_r        <= gv_nxt;
    pa_r        <= pa_nxt;
    pb_r        <= pb_nxt;
    grp_r       <= grp_nxt;
    out_index_r <= out_index_nxt;
    out_found_r <= out_found_nxt;
    out_sg_r    <= out_sg_nxt;
    out_end_r   <= out_end_nxt;
  end

  a_depths_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (d1_r <= cnt_r) && (d2_r <= cnt_r))
    else $error("stack depths exceed item count");

  a_run_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && out_end_nxt) |=> (cnt_r == '0 && d1_r == '0 && d2_r == '0))
    else $error("state not cleared after run end");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != sge_pkg::ST_IDLE))
    else $error("engine idle right after accepting a transaction");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result overwrote a pending transaction");

endmodule
